@@ rtl/assert_macros.svh @@
// Assertion helpers; clocked on clk, off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Expression must never be true.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ rtl/csba_pkg.sv @@
package csba_pkg;

	// default geometry
	localparam int CSBA_BLOCK_COUNT = 56;
	localparam int CSBA_BLOCK_BYTES = 256;
	localparam int CSBA_SLOT_COUNT  = 10;

	// field widths
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int ID_W     = 4;
	localparam int SIZE_W   = 14;
	localparam int BLK_W    = 6;

	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 72;
	localparam int M_TUSER_W = 3;

	// operations
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC  = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

	// result status
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_SLOT_EMPTY = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     slot_out;
		logic [BLK_W-1:0]    start_block;
		logic [BLK_W-1:0]    block_count;
		logic [SIZE_W-1:0]   slot_bytes;
		logic [ID_W-1:0]     next_free_slot;
		logic                move_valid;
		logic [BLK_W-1:0]    move_src_block;
		logic [BLK_W-1:0]    move_dst_block;
		logic [BLK_W-1:0]    move_block_count;
	} res_t;

endpackage

@@ rtl/csba_ram.sv @@
module csba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/compacting_slot_block_allocator.sv @@
// Compacting slot block allocator.
// Input channel s_axis: op in tuser, slot_id and size_bytes in tdata. One item in,
// one result item out on m_axis for every op (status and move flag in tuser).
// Slot descriptors (start block, byte size) live in a one-port-read, one-port-write
// RAM with a registered read; a valid bit per slot makes never-written or
// cleared slots read as empty, so clear takes effect at once.
// Allocate/delete/query: the addressed descriptor is read, its size rounded up to
// blocks by a reciprocal unit (multiply, then correct), then every slot is read
// once, in order, to find the two lowest empty slots and, on delete, to lower the
// starts above the freed slot (read-modify-write, one slot per cycle). A final
// write-back state writes the granted slot. The result then goes to the output
// register, and only after that is the next item taken; throughput is bound by
// the descriptor sweep through the single RAM read port. Clear skips the sweep.
// Reset (arst_n low) empties all slots and zeroes the block pointer; no sweep needed.
// A stalled m_axis holds its result; the next item may still be accepted and is
// worked on until its result waits for the output register to free up.
`include "assert_macros.svh"

module compacting_slot_block_allocator
	import csba_pkg::*;
#(
	parameter int BLOCK_COUNT = CSBA_BLOCK_COUNT,
	parameter int BLOCK_BYTES = CSBA_BLOCK_BYTES,
	parameter int SLOT_COUNT  = CSBA_SLOT_COUNT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [3:0] slot_id, [17:4] size_bytes, [23:18] zero
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// [1:0] op
	input  logic [S_TUSER_W-1:0] s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [3:0] slot_out, [9:4] start_block, [15:10] block_count, [29:16] slot_bytes,
	// [43:30] free_bytes, [47:44] next_free_slot, [53:48] move_src_block,
	// [59:54] move_dst_block, [65:60] move_block_count, [71:66] zero
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// [1:0] status, [2] move_valid
	output logic [M_TUSER_W-1:0] m_axis_tuser
);

	localparam int AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int PW    = $clog2(SLOT_COUNT + 1);
	localparam int NBW   = $clog2(BLOCK_COUNT + 1);
	localparam int FBW   = $clog2(BLOCK_COUNT * BLOCK_BYTES + 1);
	localparam int MW    = NBW + SIZE_W;
	// blocks_of(): x = size + BLOCK_BYTES - 1 < 2^15, q ~ x * RECIP >> DIV_K, fixed by one step
	localparam int XW    = 15;
	localparam int DIV_K = 15;
	localparam int PRW   = 30;
	localparam int RECIP = (1 << DIV_K) / BLOCK_BYTES;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_TGT  = 3'd1;
	localparam logic [2:0] S_DIV1 = 3'd2;
	localparam logic [2:0] S_DIV2 = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;
	localparam logic [2:0] S_WB   = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]            state_q;
	logic [OP_W-1:0]       op_q;
	logic [ID_W-1:0]       id_q;
	logic [SIZE_W-1:0]     size_q;
	logic [SLOT_COUNT-1:0] valid_q;
	logic [NBW-1:0]        next_block_q;
	logic                  tgt_hit_q;
	logic [NBW-1:0]        tgt_start_q;
	logic [SIZE_W-1:0]     tgt_size_q;
	logic                  fits_q;
	logic [XW-1:0]         x_q;
	logic [PRW-1:0]        prod_q;
	logic [XW-1:0]         nb_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [PW-1:0]         chk_ptr_q;
	logic [PW-1:0]         fe_q;
	logic [PW-1:0]         se_q;
	res_t                  res_q;
	res_t                  res_d;
	res_t                  res_idle;

	logic                  out_valid_q;
	res_t                  out_res_q;
	logic [SIZE_W-1:0]     out_free_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [MW-1:0]         ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [MW-1:0]         ram_rdata;

	logic                  in_acc;
	logic                  out_free;
	logic [AW-1:0]         id_idx;
	logic                  id_in_range;
	logic [AW-1:0]         chk_idx;
	logic [NBW-1:0]        rd_start;
	logic [SIZE_W-1:0]     rd_size;
	logic                  chk_empty;
	logic                  chk_lower;
	logic [NBW-1:0]        lowered;
	logic [FBW-1:0]        free_full;
	logic [XW-1:0]         q0;
	logic [XW-1:0]         rem;
	logic                  alloc_ok;
	logic [15:0]           msrc;
	logic                  del_hit;

	assign in_acc      = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign out_free    = !out_valid_q || m_axis_tready;
	assign id_idx      = AW'(id_q);
	assign id_in_range = 32'(id_q) < 32'(SLOT_COUNT);
	assign chk_idx     = chk_ptr_q[AW-1:0];
	assign rd_start    = ram_rdata[MW-1:SIZE_W];
	assign rd_size     = ram_rdata[SIZE_W-1:0];
	assign chk_empty   = !valid_q[chk_idx] || (rd_size == '0);

	// free bytes from the live block pointer
	always_comb begin
		if (next_block_q < NBW'(BLOCK_COUNT)) begin
			free_full = FBW'(NBW'(BLOCK_COUNT) - next_block_q) * FBW'(BLOCK_BYTES);
		end else begin
			free_full = '0;
		end
	end

	// rounding correction: remainder below twice the block size
	assign q0  = prod_q[DIV_K +: XW];
	assign rem = x_q - XW'(q0 * XW'(BLOCK_BYTES));

	// compaction of other slots during the sweep
	assign lowered   = (16'(rd_start) > 16'(nb_q)) ? NBW'(16'(rd_start) - 16'(nb_q)) : '0;
	assign del_hit   = (op_q == OP_DELETE) && tgt_hit_q;
	assign chk_lower = del_hit && (32'(chk_ptr_q) != 32'(id_q)) && valid_q[chk_idx]
		&& (rd_start > tgt_start_q);
	assign alloc_ok  = (op_q == OP_ALLOC) && fits_q && (fe_q != PW'(SLOT_COUNT));
	assign msrc      = 16'(tgt_start_q) + 16'(nb_q);

	always_comb begin
		ram_raddr = (state_q == S_IDLE) ? AW'(s_axis_tdata[ID_W-1:0]) : rd_ptr_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = chk_idx;
		ram_wdata = {lowered, rd_size};
		if (state_q == S_SCAN) begin
			ram_we = chk_lower;
		end else if (state_q == S_WB) begin
			ram_we    = alloc_ok;
			ram_waddr = fe_q[AW-1:0];
			ram_wdata = {next_block_q, size_q};
		end
	end

	// clear result: everything zero, slot echoed, lowest free slot 0
	always_comb begin
		res_idle          = '0;
		res_idle.status   = ST_OK;
		res_idle.slot_out = s_axis_tdata[ID_W-1:0];
	end

	// result fields, settled in the write-back cycle
	always_comb begin
		res_d                  = '0;
		res_d.status           = ST_OK;
		res_d.slot_out         = id_q;
		res_d.next_free_slot   = ID_W'(fe_q);
		if (op_q == OP_ALLOC) begin
			if (!fits_q) begin
				res_d.status = ST_NO_SPACE;
			end else if (!alloc_ok) begin
				res_d.status = ST_NO_SLOT;
			end else begin
				res_d.slot_out       = ID_W'(fe_q);
				res_d.start_block    = BLK_W'(next_block_q);
				res_d.block_count    = BLK_W'(nb_q);
				res_d.slot_bytes     = size_q;
				// a zero-size grant leaves the slot empty
				res_d.next_free_slot = (size_q == '0) ? ID_W'(fe_q) : ID_W'(se_q);
			end
		end else if (!tgt_hit_q) begin
			res_d.status = ST_SLOT_EMPTY;
		end else begin
			res_d.start_block = BLK_W'(tgt_start_q);
			res_d.block_count = BLK_W'(nb_q);
			res_d.slot_bytes  = tgt_size_q;
			if (op_q == OP_DELETE) begin
				res_d.move_valid     = 1'b1;
				res_d.move_dst_block = BLK_W'(tgt_start_q);
				res_d.move_src_block = BLK_W'(msrc);
				res_d.move_block_count = (32'(BLOCK_COUNT) > 32'(msrc)) ?
					BLK_W'(16'(BLOCK_COUNT) - msrc) : '0;
				res_d.next_free_slot = (32'(id_q) < 32'(fe_q)) ? id_q : ID_W'(fe_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			next_block_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (s_axis_tuser == OP_CLEAR) begin
							valid_q      <= '0;
							next_block_q <= '0;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_TGT;
						end
					end
				end
				S_TGT:  state_q <= S_DIV1;
				S_DIV1: state_q <= S_DIV2;
				S_DIV2: state_q <= S_SCAN;
				S_SCAN: begin
					if (chk_ptr_q == PW'(SLOT_COUNT - 1)) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (alloc_ok) begin
						valid_q[fe_q[AW-1:0]] <= 1'b1;
						next_block_q <= next_block_q + NBW'(nb_q);
					end else if (del_hit) begin
						valid_q[id_idx] <= 1'b0;
						next_block_q <= (16'(next_block_q) > 16'(nb_q)) ?
							NBW'(16'(next_block_q) - 16'(nb_q)) : '0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q     <= s_axis_tuser;
				id_q     <= s_axis_tdata[ID_W-1:0];
				size_q   <= s_axis_tdata[ID_W +: SIZE_W];
				rd_ptr_q <= '0;
				res_q    <= res_idle;
			end
			S_TGT: begin
				tgt_hit_q   <= id_in_range && valid_q[id_idx] && (rd_size != '0);
				tgt_start_q <= rd_start;
				tgt_size_q  <= (id_in_range && valid_q[id_idx]) ? rd_size : '0;
				fits_q      <= 32'(size_q) <= 32'(free_full);
				if (op_q == OP_ALLOC) begin
					x_q <= XW'(size_q) + XW'(BLOCK_BYTES - 1);
				end else if (id_in_range && valid_q[id_idx]) begin
					x_q <= XW'(rd_size) + XW'(BLOCK_BYTES - 1);
				end else begin
					x_q <= XW'(BLOCK_BYTES - 1);
				end
			end
			S_DIV1: begin
				prod_q <= PRW'(x_q) * PRW'(RECIP);
			end
			S_DIV2: begin
				nb_q      <= (32'(rem) >= 32'(BLOCK_BYTES)) ? q0 + XW'(1) : q0;
				rd_ptr_q  <= rd_ptr_q + PW'(1);
				chk_ptr_q <= '0;
				fe_q      <= PW'(SLOT_COUNT);
				se_q      <= PW'(SLOT_COUNT);
			end
			S_SCAN: begin
				rd_ptr_q  <= rd_ptr_q + PW'(1);
				chk_ptr_q <= chk_ptr_q + PW'(1);
				if (chk_empty) begin
					if (fe_q == PW'(SLOT_COUNT)) begin
						fe_q <= chk_ptr_q;
					end else if (se_q == PW'(SLOT_COUNT)) begin
						se_q <= chk_ptr_q;
					end
				end
			end
			S_WB: begin
				res_q <= res_d;
			end
			S_DONE: begin
				if (out_free) begin
					out_res_q  <= res_q;
					out_free_q <= SIZE_W'(free_full);
				end
			end
			default: ;
		endcase
	end

	csba_ram #(
		.WIDTH (MW),
		.DEPTH (SLOT_COUNT)
	) u_desc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0,
		out_res_q.move_block_count, out_res_q.move_dst_block, out_res_q.move_src_block,
		out_res_q.next_free_slot, out_free_q, out_res_q.slot_bytes,
		out_res_q.block_count, out_res_q.start_block, out_res_q.slot_out};
	assign m_axis_tuser  = {out_res_q.move_valid, out_res_q.status};

	`ASSERT_CLK(a_next_block_bound, next_block_q <= NBW'(BLOCK_COUNT), "block pointer past end of store")
	`ASSERT_CLK(a_move_only_ok, m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == ST_OK, "move command on a failed op")
	`ASSERT_CLK(a_load_from_done, $rose(m_axis_tvalid) |-> $past(state_q == S_DONE), "result shown outside done")
	`ASSERT_CLK(a_accept_leaves_idle, s_axis_tvalid && s_axis_tready |=> state_q != S_IDLE, "accepted item not started")
	`ASSERT_NEVER(a_no_write_idle, ram_we && (state_q == S_IDLE || state_q == S_DONE), "descriptor write while idle")

endmodule
